[rtl/ntfs_runlist_decoder_top_assert.svh]
// Assertion macros for the runlist decoder.
`ifndef NTFS_RUNLIST_DECODER_TOP_ASSERT_SVH
`define NTFS_RUNLIST_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH

`define NTFSRL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ntfsrl assertion failed");

`define NTFSRL_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ntfsrl reset assertion failed");

`else

`define NTFSRL_ASSERT(lbl, clk, rst_n, prop)

`define NTFSRL_ASSERT_RST(lbl, clk, prop)

`endif

`endif

[rtl/ntfsrl_pkg.sv]
package ntfsrl_pkg;

    typedef enum logic [3:0] {
        PH_HALTED = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_OFFSET = 4'b1000
    } phase_t;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_END_OK  = 2'd1;
    localparam logic [1:0] ST_BAD_RUN = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [62:0] cluster;
        logic [62:0] run_length;
        logic        last;
    } res_t;

endpackage

[rtl/ntfs_runlist_decoder_top.sv]
// Channel  Ports                                              Dir   Beat
// s_       s_valid s_ready s_data_byte s_first                in    one runlist byte
// m_       m_valid m_ready m_status m_cluster m_run_length    out   one result
//          m_last
// One byte per clock while s_ready is high; a result appears in m_ the cycle after its byte is taken.
// Header, field and cluster-add logic all sit between the parser state and the output register.
// s_ready is low during reset and while a result is held with m_ready low.
// aresetn is synchronous, active low; after reset bytes are ignored until one with s_first.
`include "ntfs_runlist_decoder_top_assert.svh"

module ntfs_runlist_decoder_top
    import ntfsrl_pkg::*;
#(
    parameter int unsigned MAX_FIELD_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [62:0] m_cluster,
    output logic [62:0] m_run_length,
    output logic        m_last
);

    res_t        res;
    logic        accept;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg;
    logic [62:0] m_cluster_reg;
    logic [62:0] m_run_length_reg;
    logic        m_last_reg;
    logic        run_beat;
    logic        end_beat;

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    ntfsrl_core #(
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (accept),
        .data_byte(s_data_byte),
        .first    (s_first),
        .res      (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next = res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            m_status_reg     <= res.status;
            m_cluster_reg    <= res.cluster;
            m_run_length_reg <= res.run_length;
            m_last_reg       <= res.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_cluster    = m_cluster_reg;
    assign m_run_length = m_run_length_reg;
    assign m_last       = m_last_reg;

    assign run_beat = m_valid && m_status == ST_RUN;
    assign end_beat = m_valid && m_status != ST_RUN;

    `NTFSRL_ASSERT(a_run_beat, aclk, aresetn, run_beat |-> (!m_last && m_run_length != 63'd0))
    `NTFSRL_ASSERT(a_end_beat, aclk, aresetn, end_beat |-> (m_last && ~|m_cluster && ~|m_run_length))
    `NTFSRL_ASSERT(a_no_phantom, aclk, aresetn, (!m_valid && !accept) |=> !m_valid)
    `NTFSRL_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_valid)

endmodule

[rtl/ntfsrl_core.sv]
module ntfsrl_core
    import ntfsrl_pkg::*;
#(
    parameter int unsigned MAX_FIELD_BYTES = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [7:0] data_byte,
    input  logic       first,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  length_size_reg, length_size_next;
    logic [3:0]  offset_size_reg, offset_size_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [63:0] length_accum_reg, length_accum_next;
    logic [63:0] delta_accum_reg, delta_accum_next;
    logic [63:0] running_cluster_reg, running_cluster_next;
    logic        run_seen_reg, run_seen_next;

    function automatic logic size_ok(input logic [3:0] size);
        return (size != 4'd0) && (32'(size) <= MAX_FIELD_BYTES);
    endfunction

    function automatic logic [63:0] take_byte(input logic [63:0] acc, input logic [3:0] size,
                                              input logic [3:0] left, input logic [7:0] b);
        logic [3:0] idx;
        idx = size - left;
        if (!size_ok(size) || left == 4'd0 || left > size) begin
            return acc;
        end
        return acc | ({56'd0, b} << {idx[2:0], 3'b000});
    endfunction

    function automatic logic [63:0] finish_field(input logic [63:0] acc, input logic [3:0] size);
        logic        sign;
        logic [63:0] r;
        if (!size_ok(size)) begin
            return 64'd0;
        end
        if (size >= 4'd8) begin
            return acc;
        end
        case (size[2:0])
            3'd1:    sign = acc[7];
            3'd2:    sign = acc[15];
            3'd3:    sign = acc[23];
            3'd4:    sign = acc[31];
            3'd5:    sign = acc[39];
            3'd6:    sign = acc[47];
            3'd7:    sign = acc[55];
            default: sign = 1'b0;
        endcase
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = (i >= int'(size)) ? {8{sign}} : acc[8*i +: 8];
        end
        return r;
    endfunction

    phase_t      eff_phase;
    logic [63:0] eff_cluster;
    logic        eff_seen;
    logic [3:0]  bl_dec;
    logic [63:0] acc_tmp;
    logic        fin;
    logic [63:0] fin_len;
    logic [63:0] fin_delta;
    logic [63:0] rc_sum;

    always_comb begin
        eff_phase   = first ? PH_HEADER : phase_reg;
        eff_cluster = first ? 64'd0 : running_cluster_reg;
        eff_seen    = first ? 1'b0 : run_seen_reg;

        phase_next           = eff_phase;
        length_size_next     = length_size_reg;
        offset_size_next     = offset_size_reg;
        bytes_left_next      = bytes_left_reg;
        length_accum_next    = length_accum_reg;
        delta_accum_next     = delta_accum_reg;
        running_cluster_next = eff_cluster;
        run_seen_next        = eff_seen;

        res       = '0;
        fin       = 1'b0;
        fin_len   = length_accum_reg;
        fin_delta = delta_accum_reg;
        bl_dec    = bytes_left_reg - 4'd1;
        acc_tmp   = 64'd0;

        unique case (eff_phase)
            PH_HEADER: begin
                if (data_byte == 8'd0) begin
                    phase_next = PH_HALTED;
                    res.valid  = 1'b1;
                    res.status = eff_seen ? ST_END_OK : ST_EMPTY;
                    res.last   = 1'b1;
                end else begin
                    length_size_next  = data_byte[7:4];
                    offset_size_next  = data_byte[3:0];
                    length_accum_next = 64'd0;
                    delta_accum_next  = 64'd0;
                    if (data_byte[7:4] != 4'd0) begin
                        phase_next      = PH_LENGTH;
                        bytes_left_next = data_byte[7:4];
                    end else if (data_byte[3:0] != 4'd0) begin
                        phase_next      = PH_OFFSET;
                        bytes_left_next = data_byte[3:0];
                    end else begin
                        fin       = 1'b1;
                        fin_len   = 64'd0;
                        fin_delta = 64'd0;
                    end
                end
            end
            PH_LENGTH: begin
                acc_tmp = take_byte(length_accum_reg, length_size_reg, bytes_left_reg,
                                    data_byte);
                bytes_left_next   = bl_dec;
                length_accum_next = acc_tmp;
                if (bl_dec == 4'd0) begin
                    length_accum_next = finish_field(acc_tmp, length_size_reg);
                    if (offset_size_reg != 4'd0) begin
                        phase_next      = PH_OFFSET;
                        bytes_left_next = offset_size_reg;
                    end else begin
                        fin     = 1'b1;
                        fin_len = length_accum_next;
                    end
                end
            end
            PH_OFFSET: begin
                acc_tmp = take_byte(delta_accum_reg, offset_size_reg, bytes_left_reg,
                                    data_byte);
                bytes_left_next  = bl_dec;
                delta_accum_next = acc_tmp;
                if (bl_dec == 4'd0) begin
                    delta_accum_next = finish_field(acc_tmp, offset_size_reg);
                    fin       = 1'b1;
                    fin_delta = delta_accum_next;
                end
            end
            default: begin
            end
        endcase

        rc_sum = eff_cluster + fin_delta;
        if (fin) begin
            running_cluster_next = rc_sum;
            res.valid = 1'b1;
            if (fin_len == 64'd0 || fin_len[63] || rc_sum[63]) begin
                phase_next = PH_HALTED;
                res.status = ST_BAD_RUN;
                res.last   = 1'b1;
            end else begin
                phase_next     = PH_HEADER;
                run_seen_next  = 1'b1;
                res.status     = ST_RUN;
                res.cluster    = rc_sum[62:0];
                res.run_length = fin_len[62:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HALTED;
            run_seen_reg <= 1'b0;
        end else if (en) begin
            phase_reg    <= phase_next;
            run_seen_reg <= run_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            length_size_reg     <= length_size_next;
            offset_size_reg     <= offset_size_next;
            bytes_left_reg      <= bytes_left_next;
            length_accum_reg    <= length_accum_next;
            delta_accum_reg     <= delta_accum_next;
            running_cluster_reg <= running_cluster_next;
        end
    end

endmodule
